// ===== rtl/mmn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the motion to MIDI note mapper.
// Used by mmn_ctrl, mmn_datapath and motion_to_midi_note_mapper.
package mmn_pkg;

	// Parameter defaults
	localparam int WINDOW_LEN_DEF  = 24;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths
	localparam int ACCEL_W = 16;
	localparam int VAL_W   = 7;
	localparam int CHAN_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int OUT_W   = 40;
	localparam int CFG_W   = 7;
	localparam int USER_W  = 2;

	// Accel scaling: 16384 counts per g, full scale 127
	localparam logic [ACCEL_W:0]     ACCEL_ONE_G  = 17'd16384;
	localparam logic [VAL_W-1:0]     VAL_MAX      = 7'd127;
	localparam logic [VAL_W-1:0]     NOTE_RESET   = 7'h3c;

	// Packet bytes
	localparam logic [BYTE_W-1:0] PKT_HEADER = 8'h80;
	localparam logic [BYTE_W-1:0] PKT_STAMP  = 8'h80;
	localparam logic [BYTE_W-1:0] NOTE_ON    = 8'h90;
	localparam logic [BYTE_W-1:0] NOTE_OFF   = 8'h80;

	// Register indexes
	localparam logic CFG_MIDI_CHANNEL = 1'b0;
	localparam logic CFG_DEFAULT_NOTE = 1'b1;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_ACCEL = 2'd1,
		MODE_GYRO  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_UPDATE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_MULT,
		ST_PREP,
		ST_DIV,
		ST_SEND_ON,
		ST_SEND_OFF
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd_old;
		logic update;
		logic scan_rd;
		logic mult;
		logic prep;
		logic div_step;
		logic off;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic connected;
		logic scan_last;
		logic div_last;
	} sts_t;

endpackage

// ===== rtl/mmn_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine for the motion to MIDI note mapper.
// Depends on mmn_pkg; drives mmn_datapath through cmd_t and reads sts_t.
module mmn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic          m_tlast,
	output mmn_pkg::cmd_t cmd,
	input  mmn_pkg::sts_t sts
);
	import mmn_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		m_tlast  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.connected) state_d = ST_RD_OLD;
				end
			end
			ST_RD_OLD: begin
				cmd.rd_old = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) state_d = ST_SCAN_LAST;
			end
			ST_SCAN_LAST: begin
				state_d = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_SEND_ON;
			end
			ST_SEND_ON: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = ST_SEND_OFF;
			end
			ST_SEND_OFF: begin
				cmd.off  = 1'b1;
				m_tvalid = 1'b1;
				m_tlast  = 1'b1;
				if (m_tready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/mmn_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, accel scaling, gyro window memory, max scan,
// serial divider and packet assembly. Depends on mmn_pkg.
module mmn_datapath #(
	parameter int WINDOW_LEN  = mmn_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF,
	parameter int IN_W        = ((1 + mmn_pkg::ACCEL_W + SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [IN_W-1:0]               s_tdata,
	input  logic [mmn_pkg::USER_W-1:0]    s_tuser,
	output logic [mmn_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [mmn_pkg::CFG_W-1:0]     cfg_wdata,
	input  mmn_pkg::cmd_t                 cmd,
	output mmn_pkg::sts_t                 sts
);
	import mmn_pkg::*;

	localparam int AW    = $clog2(WINDOW_LEN);
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
	localparam int NUM_W = SUM_W + 8;
	localparam int PROD_W = ACCEL_W + 1 + VAL_W;

	// Input field split
	logic                   in_conn;
	logic [ACCEL_W-1:0]     in_accel;
	logic [SAMPLE_BITS-1:0] in_gyro;
	assign in_conn  = s_tdata[0];
	assign in_accel = s_tdata[ACCEL_W:1];
	assign in_gyro  = s_tdata[ACCEL_W+SAMPLE_BITS:ACCEL_W+1];

	// Config registers
	logic [CHAN_W-1:0] chan_q;
	logic [VAL_W-1:0]  dflt_note_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			dflt_note_q <= NOTE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MIDI_CHANNEL: chan_q      <= cfg_wdata[CHAN_W-1:0];
				CFG_DEFAULT_NOTE: dflt_note_q <= cfg_wdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Accel scaling: round up positive, truncate negative magnitude
	logic [ACCEL_W:0]   acc_mag;
	logic [PROD_W-1:0]  acc_prod;
	logic [VAL_W-1:0]   acc_val;
	always_comb begin
		if (in_accel[ACCEL_W-1]) begin
			acc_mag  = 17'h10000 - {1'b0, in_accel};
			acc_prod = PROD_W'(acc_mag) * PROD_W'(VAL_MAX);
		end else begin
			acc_mag  = {1'b0, in_accel};
			acc_prod = PROD_W'(acc_mag) * PROD_W'(VAL_MAX) + PROD_W'(ACCEL_ONE_G - 17'd1);
		end
		if (acc_mag > ACCEL_ONE_G) acc_val = VAL_MAX;
		else acc_val = acc_prod[14 +: VAL_W];
	end

	// Gyro magnitude: the most negative sample fits exactly
	logic [SAMPLE_BITS-1:0] gyro_mag;
	assign gyro_mag = in_gyro[SAMPLE_BITS-1] ? (~in_gyro + 1'b1) : in_gyro;

	// Capture the item; the mode follows the buttons, side wins
	mode_t                  mode_q;
	logic [VAL_W-1:0]       acc_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (cmd.load) begin
			if (s_tuser[1]) mode_q <= MODE_GYRO;
			else if (s_tuser[0]) mode_q <= MODE_ACCEL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= acc_val;
			mag_q <= gyro_mag;
		end
	end

	// Window memory, circular, with per-entry valid bits
	logic [SAMPLE_BITS-1:0] win_mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]  valid_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          scan_cnt_q;
	logic [AW-1:0]          rd_addr;
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic                   rd_vld_q;
	logic [SAMPLE_BITS-1:0] rd_val;
	logic                   pend_q;

	assign rd_addr = cmd.rd_old ? wp_q : scan_cnt_q;
	assign rd_val  = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.update) win_mem[wp_q] <= mag_q;
		rd_data_q <= win_mem[rd_addr];
		rd_vld_q  <= valid_q[rd_addr];
	end

	// Running sum, write pointer, scan counter and max; the counter stops on the last entry
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] mx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			wp_q       <= '0;
			sum_q      <= '0;
			scan_cnt_q <= '0;
			pend_q     <= 1'b0;
		end else begin
			pend_q <= cmd.scan_rd;
			if (cmd.update) begin
				valid_q[wp_q] <= 1'b1;
				sum_q         <= sum_q - SUM_W'(rd_val) + SUM_W'(mag_q);
				wp_q          <= (wp_q == AW'(WINDOW_LEN - 1)) ? '0 : wp_q + 1'b1;
				scan_cnt_q    <= '0;
			end else if (cmd.scan_rd && (scan_cnt_q != AW'(WINDOW_LEN - 1))) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) mx_q <= '0;
		else if (pend_q && rd_val > mx_q) mx_q <= rd_val;
	end

	// Excess, numerator and restoring division, one quotient bit a cycle
	logic [SUM_W-1:0] diff_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsr_q;
	logic [7:0]       quot_q;
	logic [2:0]       div_cnt_q;
	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			diff_q <= SUM_W'(mx_q) * SUM_W'(WINDOW_LEN) - sum_q;
		end
		if (cmd.prep) begin
			rem_q     <= (NUM_W'(diff_q) << 7) - NUM_W'(diff_q) + NUM_W'(sum_q) - 1'b1;
			dsr_q     <= NUM_W'(sum_q) << 7;
			quot_q    <= '0;
			div_cnt_q <= 3'd7;
		end else if (cmd.div_step) begin
			if (rem_q >= dsr_q) begin
				rem_q             <= rem_q - dsr_q;
				quot_q[div_cnt_q] <= 1'b1;
			end
			dsr_q     <= dsr_q >> 1;
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// Gyro value with clamp and empty-window case
	logic [VAL_W-1:0] gyr_val;
	always_comb begin
		if (sum_q == '0) gyr_val = '0;
		else if (quot_q[7]) gyr_val = VAL_MAX;
		else gyr_val = quot_q[VAL_W-1:0];
	end

	// Mode routing and packet assembly
	logic [VAL_W-1:0]  note;
	logic [VAL_W-1:0]  vel;
	logic [BYTE_W-1:0] status;
	always_comb begin
		case (mode_q)
			MODE_ACCEL: begin
				note = acc_q;
				vel  = gyr_val;
			end
			MODE_GYRO: begin
				note = gyr_val;
				vel  = acc_q;
			end
			default: begin
				note = dflt_note_q;
				vel  = '0;
			end
		endcase
		status  = (cmd.off ? NOTE_OFF : NOTE_ON) | {4'b0, chan_q};
		m_tdata = {2'b0, (cmd.off ? {VAL_W{1'b0}} : vel), note, status, PKT_STAMP,
			PKT_HEADER};
	end

	// Status
	assign sts.connected = in_conn;
	assign sts.scan_last = (scan_cnt_q == AW'(WINDOW_LEN - 1));
	assign sts.div_last  = (div_cnt_q == 3'd0);

endmodule

// ===== rtl/motion_to_midi_note_mapper.sv =====
`timescale 1ns / 1ps
// Motion to MIDI note mapper top level: joins mmn_ctrl and mmn_datapath; needs mmn_pkg.
// Note-on is offered after the old-entry read, window update, max scan, multiply and
// divide steps; note-off follows once note-on is taken. A new item is accepted only
// in idle, once note-off is taken; the one-entry-a-cycle window max scan and an 8-step
// divider set the pace; a link-down item yields no packet. Reset clears mode, window valid
// bits, sum and config (channel 0, default note 60); ready right after reset.
module motion_to_midi_note_mapper #(
	parameter int WINDOW_LEN  = mmn_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF,
	parameter int IN_W        = ((1 + mmn_pkg::ACCEL_W + SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// connected, accel_x, gyro_x (from bit 0 up)
	input  logic [IN_W-1:0]            s_tdata,
	// front_pressed, side_pressed (from bit 0 up)
	input  logic [mmn_pkg::USER_W-1:0] s_tuser,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// header_byte, timestamp_byte, status_byte, note, velocity (from bit 0 up)
	output logic [mmn_pkg::OUT_W-1:0]  m_tdata,
	output logic                       m_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [mmn_pkg::CFG_W-1:0]  cfg_wdata
);
	import mmn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	mmn_datapath #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IN_W        (IN_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
